// File: hdl/bscu_pkg.sv
// ----------------------------------------------------------------------------
// bscu_pkg
// Widths, shift amounts, register indexes and shared types of the barometric
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bscu_pkg;

    localparam int RAW_W      = 24;
    localparam int COEF_W     = 16;
    localparam int DT_W       = 25;
    localparam int MPROD_W    = 42;
    localparam int OFF_W      = 36;
    localparam int SENS_W     = 35;
    localparam int SENS_LO_W  = 18;
    localparam int PP_W       = 42;
    localparam int PROD_W     = 60;
    localparam int Q_W        = 39;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 22;
    localparam int NUM_STAGES = 7;
    localparam int CFG_ADDR_W = 3;

    localparam int C5_SHIFT   = 8;
    localparam int C2_SHIFT   = 16;
    localparam int C1_SHIFT   = 15;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int TEMP_SHIFT = 23;
    localparam int PROD_SHIFT = 21;
    localparam int PRES_SHIFT = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        IDX_PRESSURE_SENSITIVITY  = 3'd0,
        IDX_PRESSURE_OFFSET       = 3'd1,
        IDX_SENS_TEMP_COEFF       = 3'd2,
        IDX_OFFSET_TEMP_COEFF     = 3'd3,
        IDX_REFERENCE_TEMPERATURE = 3'd4,
        IDX_TEMP_SENSITIVITY      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } coeff_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

// File: hdl/bscu_regs.sv
// ----------------------------------------------------------------------------
// bscu_regs
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bscu_regs
    import bscu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_data,
    output coeff_t                coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    always_comb begin
        coeff_next = coeff_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                IDX_PRESSURE_SENSITIVITY:  coeff_next.c1 = cfg_data;
                IDX_PRESSURE_OFFSET:       coeff_next.c2 = cfg_data;
                IDX_SENS_TEMP_COEFF:       coeff_next.c3 = cfg_data;
                IDX_OFFSET_TEMP_COEFF:     coeff_next.c4 = cfg_data;
                IDX_REFERENCE_TEMPERATURE: coeff_next.c5 = cfg_data;
                IDX_TEMP_SENSITIVITY:      coeff_next.c6 = cfg_data;
                default:                   coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign coeff     = coeff_reg;

endmodule

// File: hdl/bscu_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// bscu_pipe_ctrl
// Stage valid bits and per-stage load enables; empty stages fill while the
// output stage waits.
// ----------------------------------------------------------------------------
module bscu_pipe_ctrl
    import bscu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NUM_STAGES-1];
    assign ctrl.en = en;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&v_reg) && !m_ready))
        else $error("input stalled with an empty stage");

    a_count_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(v_reg) == $past($countones(v_reg))
            + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready)))
        else $error("request lost or duplicated in pipeline");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("pipeline not empty after reset");

endmodule

// File: hdl/bscu_calc_front.sv
// ----------------------------------------------------------------------------
// bscu_calc_front
// Stages one to three: temperature difference, coefficient products, and
// offset, sensitivity and compensated temperature.
// ----------------------------------------------------------------------------
module bscu_calc_front
    import bscu_pkg::*;
(
    input  logic                     aclk,
    input  pipe_ctrl_t               ctrl,
    input  coeff_t                   coeff,
    input  logic [RAW_W-1:0]         s_pressure_raw,
    input  logic [RAW_W-1:0]         s_temperature_raw,
    output logic [RAW_W-1:0]         d1,
    output logic signed [OFF_W-1:0]  off,
    output logic signed [SENS_W-1:0] sens,
    output logic signed [TEMP_W-1:0] temp
);

    logic [RAW_W-1:0]          d1_s1_reg;
    logic [RAW_W-1:0]          d1_s2_reg;
    logic [RAW_W-1:0]          d1_s3_reg;
    logic signed [DT_W-1:0]    dt_reg;
    logic signed [DT_W-1:0]    dt_next;
    logic signed [MPROD_W-1:0] p3_reg;
    logic signed [MPROD_W-1:0] p4_reg;
    logic signed [MPROD_W-1:0] p6_reg;
    logic signed [MPROD_W-1:0] p3_next;
    logic signed [MPROD_W-1:0] p4_next;
    logic signed [MPROD_W-1:0] p6_next;
    logic signed [MPROD_W-1:0] off_q;
    logic signed [MPROD_W-1:0] sens_q;
    logic signed [MPROD_W-1:0] temp_q;
    logic signed [OFF_W-1:0]   off_reg;
    logic signed [OFF_W-1:0]   off_next;
    logic signed [SENS_W-1:0]  sens_reg;
    logic signed [SENS_W-1:0]  sens_next;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic signed [TEMP_W-1:0]  temp_next;

    always_comb begin
        dt_next = $signed({1'b0, s_temperature_raw})
                - $signed({1'b0, coeff.c5, {C5_SHIFT{1'b0}}});

        p3_next = $signed({1'b0, coeff.c3}) * dt_reg;
        p4_next = $signed({1'b0, coeff.c4}) * dt_reg;
        p6_next = $signed({1'b0, coeff.c6}) * dt_reg;

        off_q  = (p4_reg + $signed({{(MPROD_W-OFF_SHIFT){1'b0}},
                                    {OFF_SHIFT{p4_reg[MPROD_W-1]}}})) >>> OFF_SHIFT;
        sens_q = (p3_reg + $signed({{(MPROD_W-SENS_SHIFT){1'b0}},
                                    {SENS_SHIFT{p3_reg[MPROD_W-1]}}})) >>> SENS_SHIFT;
        temp_q = (p6_reg + $signed({{(MPROD_W-TEMP_SHIFT){1'b0}},
                                    {TEMP_SHIFT{p6_reg[MPROD_W-1]}}})) >>> TEMP_SHIFT;

        off_next  = $signed({{(OFF_W-COEF_W-C2_SHIFT){1'b0}}, coeff.c2, {C2_SHIFT{1'b0}}})
                  + $signed(off_q[OFF_W-1:0]);
        sens_next = $signed({{(SENS_W-COEF_W-C1_SHIFT){1'b0}}, coeff.c1, {C1_SHIFT{1'b0}}})
                  + $signed(sens_q[SENS_W-1:0]);
        temp_next = TEMP_BASE + $signed(temp_q[TEMP_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            d1_s1_reg <= s_pressure_raw;
            dt_reg    <= dt_next;
        end
        if (ctrl.en[1]) begin
            d1_s2_reg <= d1_s1_reg;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p6_reg    <= p6_next;
        end
        if (ctrl.en[2]) begin
            d1_s3_reg <= d1_s2_reg;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
            temp_reg  <= temp_next;
        end
    end

    assign d1   = d1_s3_reg;
    assign off  = off_reg;
    assign sens = sens_reg;
    assign temp = temp_reg;

endmodule

// File: hdl/bscu_calc_pres.sv
// ----------------------------------------------------------------------------
// bscu_calc_pres
// Stages four to seven: raw pressure times sensitivity as two partial
// products, offset removal and final scaling into the output register.
// ----------------------------------------------------------------------------
module bscu_calc_pres
    import bscu_pkg::*;
(
    input  logic                     aclk,
    input  pipe_ctrl_t               ctrl,
    input  logic [RAW_W-1:0]         d1,
    input  logic signed [OFF_W-1:0]  off,
    input  logic signed [SENS_W-1:0] sens,
    input  logic signed [TEMP_W-1:0] temp,
    output logic signed [TEMP_W-1:0] m_temperature_centi,
    output logic signed [PRES_W-1:0] m_pressure_centi
);

    logic [PP_W-1:0]          pp_lo_reg;
    logic [PP_W-1:0]          pp_lo_next;
    logic signed [PP_W-1:0]   pp_hi_reg;
    logic signed [PP_W-1:0]   pp_hi_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_q;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [Q_W-1:0]    q_next;
    logic signed [Q_W-1:0]    pres_q;
    logic signed [OFF_W-1:0]  off_s4_reg;
    logic signed [OFF_W-1:0]  off_s5_reg;
    logic signed [TEMP_W-1:0] temp_s4_reg;
    logic signed [TEMP_W-1:0] temp_s5_reg;
    logic signed [TEMP_W-1:0] temp_s6_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;
    logic signed [PRES_W-1:0] pres_out_reg;

    always_comb begin
        pp_lo_next = d1 * sens[SENS_LO_W-1:0];
        pp_hi_next = $signed({1'b0, d1}) * $signed(sens[SENS_W-1:SENS_LO_W]);

        prod_next = $signed({pp_hi_reg, {SENS_LO_W{1'b0}}})
                  + $signed({{(PROD_W-PP_W){1'b0}}, pp_lo_reg});

        prod_q = (prod_reg + $signed({{(PROD_W-PROD_SHIFT){1'b0}},
                                      {PROD_SHIFT{prod_reg[PROD_W-1]}}})) >>> PROD_SHIFT;
        q_next = $signed(prod_q[Q_W-1:0])
               - $signed({{(Q_W-OFF_W){off_s5_reg[OFF_W-1]}}, off_s5_reg});

        pres_q = (q_reg + $signed({{(Q_W-PRES_SHIFT){1'b0}},
                                   {PRES_SHIFT{q_reg[Q_W-1]}}})) >>> PRES_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            off_s4_reg  <= off;
            temp_s4_reg <= temp;
        end
        if (ctrl.en[4]) begin
            prod_reg    <= prod_next;
            off_s5_reg  <= off_s4_reg;
            temp_s5_reg <= temp_s4_reg;
        end
        if (ctrl.en[5]) begin
            q_reg       <= q_next;
            temp_s6_reg <= temp_s5_reg;
        end
        if (ctrl.en[6]) begin
            pres_out_reg <= $signed(pres_q[PRES_W-1:0]);
            temp_out_reg <= temp_s6_reg;
        end
    end

    assign m_temperature_centi = temp_out_reg;
    assign m_pressure_centi    = pres_out_reg;

endmodule

// File: hdl/baro_sensor_compensation_unit.sv
// Each stage holds one register between an accepted request and its result.
// Throughput: one request per cycle unless a full pipeline waits on m_ready;
// set by the seven-stage arithmetic pipeline, with the pressure product formed
// as two partial products in its own stages.
// Empty stages keep filling while a result waits at the output register.
// Reset (aresetn low, synchronous) clears all stage valid bits and zeroes the coefficients.
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// First-order barometric sensor compensation: raw pressure and temperature
// conversions in, temperature and pressure in hundredths out.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit
    import bscu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [COEF_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [RAW_W-1:0]         s_pressure_raw,
    input  logic [RAW_W-1:0]         s_temperature_raw,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temperature_centi,
    output logic signed [PRES_W-1:0] m_pressure_centi
);

    coeff_t                   coeff;
    pipe_ctrl_t               ctrl;
    logic [RAW_W-1:0]         d1;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic signed [TEMP_W-1:0] temp;

    bscu_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    bscu_pipe_ctrl u_pipe_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    bscu_calc_front u_calc_front (
        .aclk              (aclk),
        .ctrl              (ctrl),
        .coeff             (coeff),
        .s_pressure_raw    (s_pressure_raw),
        .s_temperature_raw (s_temperature_raw),
        .d1                (d1),
        .off               (off),
        .sens              (sens),
        .temp              (temp)
    );

    bscu_calc_pres u_calc_pres (
        .aclk                (aclk),
        .ctrl                (ctrl),
        .d1                  (d1),
        .off                 (off),
        .sens                (sens),
        .temp                (temp),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_centi    (m_pressure_centi)
    );

endmodule

// File: bench/baro_sensor_compensation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit_tb
// Feeds raw pressure/temperature request pairs through the compensation unit
// under several coefficient sets (reset zeros, a typical factory set, all-ones,
// random mixes with extremes) and compares every reading against an in-bench
// first-order compensation computed at 64-bit width. Both channels idle and
// stall in random bursts; one long output hold backs up the pipeline.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit_tb;
    import bscu_pkg::*;

    localparam int NUM_COEFFS     = 6;
    localparam int PIPE_SETTLE    = NUM_STAGES + 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 110;
    localparam int RANDOM_PHASES  = 6;
    localparam logic [RAW_W-1:0]      RAW_MAX   = '1;
    localparam logic [COEF_W-1:0]     COEF_MAX  = '1;
    localparam logic [CFG_ADDR_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0] pressure_raw;
        logic [RAW_W-1:0] temperature_raw;
    } raw_pair_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_centi;
    } reading_t;

    logic                     aclk              = 1'b0;
    logic                     aresetn           = 1'b0;
    logic                     cfg_valid         = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_W-1:0]    cfg_addr          = '0;
    logic [COEF_W-1:0]        cfg_data          = '0;
    logic                     s_valid           = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_pressure_raw    = '0;
    logic [RAW_W-1:0]         s_temperature_raw = '0;
    logic                     m_valid;
    logic                     m_ready           = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_centi;
    logic signed [PRES_W-1:0] m_pressure_centi;

    logic [COEF_W-1:0] coeff_shadow [NUM_COEFFS];
    raw_pair_t         sample_q [$];
    reading_t          reading_q [$];
    raw_pair_t         in_flight   = '0;
    raw_pair_t         next_sample;
    reading_t          want;
    int                errors      = 0;
    int                src_gap     = 0;
    int                sink_stall  = 0;
    int                holds_req   = 0;
    int                holds_done  = 0;
    int                stuck_cycles = 0;
    bit                bursty      = 1'b1;

    baro_sensor_compensation_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_addr            (cfg_addr),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pressure_raw      (s_pressure_raw),
        .s_temperature_raw   (s_temperature_raw),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_centi    (m_pressure_centi)
    );

    always #5 aclk = ~aclk;

    function automatic reading_t compensate(input raw_pair_t raw);
        longint d1, d2, dt, offset, sens, temp, pres;
        reading_t r;
        d1     = longint'(raw.pressure_raw);
        d2     = longint'(raw.temperature_raw);
        dt     = d2 - longint'(coeff_shadow[IDX_REFERENCE_TEMPERATURE]) * 256;
        offset = longint'(coeff_shadow[IDX_PRESSURE_OFFSET]) * 65536
               + (longint'(coeff_shadow[IDX_OFFSET_TEMP_COEFF]) * dt) / 128;
        sens   = longint'(coeff_shadow[IDX_PRESSURE_SENSITIVITY]) * 32768
               + (longint'(coeff_shadow[IDX_SENS_TEMP_COEFF]) * dt) / 256;
        temp   = 2000 + (dt * longint'(coeff_shadow[IDX_TEMP_SENSITIVITY])) / 8388608;
        pres   = ((d1 * sens) / 2097152 - offset) / 32768;
        r.temperature_centi = temp[TEMP_W-1:0];
        r.pressure_centi    = pres[PRES_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // request source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                reading_q.push_back(compensate(in_flight));
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (sample_q.size() > 0) begin
                    next_sample = sample_q.pop_front();
                    in_flight         <= next_sample;
                    s_pressure_raw    <= next_sample.pressure_raw;
                    s_temperature_raw <= next_sample.temperature_raw;
                    s_valid           <= 1'b1;
                    if (bursty && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(1, 9);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // reading sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (reading_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected reading temp=%0d pres=%0d",
                                              m_temperature_centi, m_pressure_centi));
                end else begin
                    want = reading_q.pop_front();
                    if (m_temperature_centi !== want.temperature_centi) begin
                        report_mismatch($sformatf("temperature_centi got %0d expected %0d",
                                                  m_temperature_centi, want.temperature_centi));
                    end
                    if (m_pressure_centi !== want.pressure_centi) begin
                        report_mismatch($sformatf("pressure_centi got %0d expected %0d",
                                                  m_pressure_centi, want.pressure_centi));
                    end
                end
            end
            if (holds_done != holds_req) begin
                holds_done <= holds_req;
                m_ready    <= 1'b0;
                sink_stall <= LONG_HOLD - 1;
            end else if (sink_stall > 0) begin
                m_ready    <= 1'b0;
                sink_stall <= sink_stall - 1;
            end else if (bursty && $urandom_range(0, 7) == 0) begin
                m_ready    <= 1'b0;
                sink_stall <= $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("baro_sensor_compensation_unit_tb NOT OK");
        $finish;
    end

    task automatic write_coeff(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_COEFFS) begin
            coeff_shadow[idx] = val;
        end
    endtask

    task automatic load_coeffs(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
        write_coeff(IDX_PRESSURE_SENSITIVITY, c1);
        write_coeff(IDX_PRESSURE_OFFSET, c2);
        write_coeff(IDX_SENS_TEMP_COEFF, c3);
        write_coeff(IDX_OFFSET_TEMP_COEFF, c4);
        write_coeff(IDX_REFERENCE_TEMPERATURE, c5);
        write_coeff(IDX_TEMP_SENSITIVITY, c6);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        raw_pair_t p;
        p.pressure_raw    = d1;
        p.temperature_raw = d2;
        sample_q.push_back(p);
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || reading_q.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEF_MAX;
            default: return COEF_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RAW_MAX;
            default: return RAW_W'($urandom_range(0, 16777215));
        endcase
    endfunction

    // temperature conversion, mostly near the reference point as a live sensor gives
    function automatic logic [RAW_W-1:0] pick_temperature_raw();
        int t;
        if ($urandom_range(0, 2) == 0) begin
            return pick_raw();
        end
        t = int'(coeff_shadow[IDX_REFERENCE_TEMPERATURE]) * 256
          + int'($urandom_range(0, 2097152)) - 1048576;
        if (t < 0) begin
            t = 0;
        end else if (t > int'(RAW_MAX)) begin
            t = int'(RAW_MAX);
        end
        return t[RAW_W-1:0];
    endfunction

    initial begin
        for (int i = 0; i < NUM_COEFFS; i++) begin
            coeff_shadow[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coefficients still at their reset value
        push_sample(RAW_MAX, RAW_MAX);
        push_sample('0, '0);
        push_sample(24'd123456, 24'd654321);
        drain();

        // typical factory set
        load_coeffs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        push_sample(24'd9085466, 24'd8569150);
        push_sample('0, '0);
        push_sample(RAW_MAX, RAW_MAX);
        push_sample('0, RAW_MAX);
        push_sample(RAW_MAX, '0);
        push_sample(RAW_MAX, RAW_W'(33464 * 256));
        push_sample(24'd9085466, RAW_W'(33464 * 256 - 1));
        push_sample(24'd9085466, RAW_W'(33464 * 256 + 1));
        push_sample(24'hAAAAAA, 24'h555555);
        push_sample(24'h555555, 24'hAAAAAA);
        drain();

        // all coefficients at full scale
        load_coeffs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        push_sample('0, '0);
        push_sample(RAW_MAX, RAW_MAX);
        push_sample(RAW_MAX, '0);
        push_sample('0, RAW_MAX);
        push_sample(RAW_MAX, RAW_W'(65535 * 256));
        drain();

        // writes to unused indexes must leave the coefficients alone
        write_coeff(IDX_SPARE_LO, 16'h1234);
        write_coeff(IDX_SPARE_HI, COEF_MAX);
        cfg_valid <= 1'b0;
        push_sample(RAW_MAX, '0);
        push_sample(24'd8000000, 24'd8500000);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            bursty = (ph != RANDOM_PHASES - 1);
            load_coeffs(pick_coeff(), pick_coeff(), pick_coeff(),
                        pick_coeff(), pick_coeff(), pick_coeff());
            if (ph == 1) begin
                holds_req++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(pick_raw(), pick_temperature_raw());
            end
            drain();
        end

        if (errors == 0) begin
            $display("baro_sensor_compensation_unit_tb OK");
        end else begin
            $display("baro_sensor_compensation_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/bscu_pkg.sv
hdl/bscu_regs.sv
hdl/bscu_pipe_ctrl.sv
hdl/bscu_calc_front.sv
hdl/bscu_calc_pres.sv
hdl/baro_sensor_compensation_unit.sv
bench/baro_sensor_compensation_unit_tb.sv
